@@ src/frustum_box_cull_unit_assert.svh @@
// Assertion macros for the frustum box cull unit checker.
// Depends on nothing; the including module provides clk and rst.
`ifndef FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_CULL_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define FBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fbc_pkg.sv @@
// Shared types, constants and plane derivation for the frustum box cull unit.
// No dependencies.
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int NUM_CELLS = 6;
  localparam int MAT_DEPTH = 16;
  localparam int VAL_W     = 32;
  localparam int NRM_W     = VAL_W + 1;
  localparam int PROD_W    = NRM_W + VAL_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_W    = 16;
  localparam int LATENCY   = 2 * NUM_CELLS;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_BOX   = 1'b1
  } op_t;

  // x, y, z, w normal components of one clip plane
  typedef logic [3:0][NRM_W-1:0] plane_t;
  typedef logic [MAT_DEPTH-1:0][VAL_W-1:0] matrix_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] lo;
    logic [2:0][VAL_W-1:0] hi;
  } box_t;

  // What one cell hands to the next
  typedef struct packed {
    logic valid;
    logic vis;
    box_t box;
  } stage_t;

  // Plane k: column four plus (k even) or minus (k odd) column k/2
  function automatic plane_t plane_of(input matrix_t m, input logic [2:0] k);
    plane_t            p;
    logic [NRM_W-1:0]  base;
    logic [NRM_W-1:0]  other;
    logic [3:0]        bidx;
    logic [3:0]        oidx;
    for (int j = 0; j < 4; j++) begin
      bidx  = {2'(j), 2'd3};
      oidx  = {2'(j), k[2:1]};
      base  = {m[bidx][VAL_W-1], m[bidx]};
      other = {m[oidx][VAL_W-1], m[oidx]};
      p[j]  = k[0] ? (base - other) : (base + other);
    end
    return p;
  endfunction

endpackage

@@ src/fbc_cell.sv @@
// One plane cell: holds a clip plane and tests the passing box against it.
// Depends on fbc_pkg.
`timescale 1ns / 1ps

module fbc_cell import fbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   refresh,
  input  plane_t plane_in,
  input  stage_t din,
  output stage_t dout,
  output logic   occupied
);

  plane_t                 plane;
  logic                   mid_valid;
  logic                   mid_vis;
  box_t                   mid_box;
  logic [2:0][PROD_W-1:0] mid_prod;
  logic [2:0][PROD_W-1:0] prod;
  logic [2:0][VAL_W-1:0]  corner;
  logic [ACC_W-1:0]       acc;
  logic                   out_valid;
  logic                   out_vis;
  box_t                   out_box;

  // Plane register, reloaded after a matrix write
  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (refresh) begin
      plane <= plane_in;
    end
  end

  // p-vertex pick and products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      corner[j] = ($signed(plane[j]) > 0) ? din.box.hi[j] : din.box.lo[j];
      prod[j]   = $signed({{(PROD_W-NRM_W){plane[j][NRM_W-1]}}, plane[j]}) *
                  $signed({{(PROD_W-VAL_W){corner[j][VAL_W-1]}}, corner[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    mid_vis  <= din.vis;
    mid_box  <= din.box;
    mid_prod <= prod;
  end

  // Plane distance with the offset scaled to Q35.32; negative means culled
  always_comb begin
    acc = {{(ACC_W-PROD_W){mid_prod[0][PROD_W-1]}}, mid_prod[0]} +
          {{(ACC_W-PROD_W){mid_prod[1][PROD_W-1]}}, mid_prod[1]} +
          {{(ACC_W-PROD_W){mid_prod[2][PROD_W-1]}}, mid_prod[2]} +
          {{(ACC_W-NRM_W-FRAC_W){plane[3][NRM_W-1]}}, plane[3], {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_vis <= mid_vis & ~acc[ACC_W-1];
    out_box <= mid_box;
  end

  assign dout.valid = out_valid;
  assign dout.vis   = out_vis;
  assign dout.box   = out_box;
  assign occupied   = mid_valid | out_valid;

endmodule

@@ src/frustum_box_cull_unit.sv @@
// Top level of the frustum box cull unit: matrix store, write sequencing and
// the chain of six plane cells. Depends on fbc_pkg and fbc_cell.
`timescale 1ns / 1ps
//
// Channel   Handshake            Payload
// command   start / busy         op, entry_index, entry_value, min_*, max_*
// result    done (one-cycle)     intersects
//
// A box transaction produces intersects after two register stages per plane
// cell, six cells; boxes can be accepted every cycle while busy is low.
// A write transaction is held until all boxes in flight drain, then stored,
// after which the cell planes are reloaded. busy is high
// throughout. Reset clears the matrix to zero and empties the chain.
// The receiver cannot stall: done pulses for one cycle per box.

module frustum_box_cull_unit import fbc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             op,
  input  logic [3:0]       entry_index,
  input  logic [VAL_W-1:0] entry_value,
  input  logic [VAL_W-1:0] min_x,
  input  logic [VAL_W-1:0] min_y,
  input  logic [VAL_W-1:0] min_z,
  input  logic [VAL_W-1:0] max_x,
  input  logic [VAL_W-1:0] max_y,
  input  logic [VAL_W-1:0] max_z,
  output logic             done,
  output logic             intersects
);

  matrix_t                matrix;
  logic                   pend_valid;
  logic [3:0]             pend_index;
  logic [VAL_W-1:0]       pend_value;
  logic                   refresh;
  logic                   accept;
  logic                   inflight;
  logic [NUM_CELLS-1:0]   occ;
  stage_t                 link [NUM_CELLS+1];

  assign busy   = pend_valid | refresh;
  assign accept = start & ~busy;
  assign inflight = |occ;

  // Write sequencing: park the write, drain, store, reload planes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      refresh    <= 1'b0;
      matrix     <= '0;
    end else begin
      refresh <= 1'b0;
      if (accept && op == OP_WRITE) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && !inflight) begin
        pend_valid         <= 1'b0;
        matrix[pend_index] <= pend_value;
        refresh            <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_WRITE) begin
      pend_index <= entry_index;
      pend_value <= entry_value;
    end
  end

  // Chain entry
  assign link[0].valid  = accept & (op == OP_BOX);
  assign link[0].vis    = 1'b1;
  assign link[0].box.lo = {min_z, min_y, min_x};
  assign link[0].box.hi = {max_z, max_y, max_x};

  // Plane cells
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    fbc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .refresh  (refresh),
      .plane_in (plane_of(matrix, 3'(g))),
      .din      (link[g]),
      .dout     (link[g+1]),
      .occupied (occ[g])
    );
  end

  assign done       = link[NUM_CELLS].valid;
  assign intersects = link[NUM_CELLS].vis;

endmodule

@@ src/fbc_checker.sv @@
// Port-level checker for the frustum box cull unit, bound to the top level.
// Depends on fbc_pkg and frustum_box_cull_unit_assert.svh.
`timescale 1ns / 1ps
`include "frustum_box_cull_unit_assert.svh"

module fbc_checker import fbc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic op,
  input logic done
);

  logic box_acc;
  logic wr_acc;

  assign box_acc = start && !busy && op == OP_BOX;
  assign wr_acc  = start && !busy && op == OP_WRITE;

  // Each box transaction yields exactly one result, at fixed latency
  `FBC_ASSERT_NOW(a_box_result, box_acc, ##LATENCY done, "box result missing")
  `FBC_ASSERT_NOW(a_no_phantom, done, $past(box_acc, LATENCY), "result without box")
  // A write blocks the command port in the next cycle
  `FBC_ASSERT_NEXT(a_write_busy, wr_acc, busy, "busy not raised after write")

endmodule

bind frustum_box_cull_unit fbc_checker u_fbc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .op    (op),
  .done  (done)
);

@@ dv/tb_top.sv @@
// Testbench for frustum_box_cull_unit: directed table, then randomized matrix
// loads and box streams checked against an in-bench culling predictor.
// Depends on fbc_pkg and the frustum_box_cull_unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import fbc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1300;

  // One command transaction, plus an optional hand-typed expectation
  typedef struct packed {
    op_t                   op;
    logic [3:0]            idx;
    logic [VAL_W-1:0]      val;
    logic [2:0][VAL_W-1:0] lo;
    logic [2:0][VAL_W-1:0] hi;
    logic                  pinned;
    logic                  pinned_vis;
  } cmd_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             op = OP_WRITE;
  logic [3:0]       entry_index = '0;
  logic [VAL_W-1:0] entry_value = '0;
  logic [VAL_W-1:0] min_x = '0, min_y = '0, min_z = '0;
  logic [VAL_W-1:0] max_x = '0, max_y = '0, max_z = '0;
  logic             done;
  logic             intersects;

  // Travels with the command so the monitor knows about typed expectations
  logic             pin_en = 1'b0;
  logic             pin_vis = 1'b0;

  // Bench copy of the matrix and results still owed by the block
  logic signed [VAL_W-1:0] mat_model [MAT_DEPTH];
  bit                      visible_q [$];
  cmd_t                    plan_q [$];

  int fails = 0;
  int cycles = 0;
  int n_writes = 0;
  int n_boxes = 0;
  int n_visible = 0;
  int n_culled = 0;
  int idle_pct = 0;

  frustum_box_cull_unit uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .min_x       (min_x),
    .min_y       (min_y),
    .min_z       (min_z),
    .max_x       (max_x),
    .max_y       (max_y),
    .max_z       (max_z),
    .done        (done),
    .intersects  (intersects)
  );

  always #2 clk = ~clk;

  // p-vertex test of one box against the six planes of the bench matrix
  function automatic bit predict_visible(input logic [2:0][VAL_W-1:0] lo,
                                         input logic [2:0][VAL_W-1:0] hi);
    logic signed [VAL_W:0]   nrm [4];
    logic signed [VAL_W:0]   base;
    logic signed [VAL_W:0]   other;
    logic signed [VAL_W-1:0] crn;
    logic signed [71:0]      acc;
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 4; j++) begin
        base   = mat_model[j*4 + 3];
        other  = mat_model[j*4 + k/2];
        nrm[j] = (k % 2 == 1) ? base - other : base + other;
      end
      acc = nrm[3];
      acc = acc <<< FRAC_W;
      for (int j = 0; j < 3; j++) begin
        if (nrm[j] > 0) crn = hi[j];
        else crn = lo[j];
        acc = acc + nrm[j] * crn;
      end
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Write commands carry random box fields, which the block must ignore
  function automatic cmd_t mk_write(input logic [3:0] idx, input logic [VAL_W-1:0] val);
    cmd_t c;
    c.op         = OP_WRITE;
    c.idx        = idx;
    c.val        = val;
    for (int a = 0; a < 3; a++) begin
      c.lo[a] = $urandom;
      c.hi[a] = $urandom;
    end
    c.pinned     = 1'b0;
    c.pinned_vis = 1'b0;
    return c;
  endfunction

  // Box commands carry junk in the write fields, which must be ignored too
  function automatic cmd_t mk_box(input logic [VAL_W-1:0] lx, ly, lz, hx, hy, hz);
    cmd_t c;
    c.op         = OP_BOX;
    c.idx        = 4'(~$urandom_range(0, 15));
    c.val        = $urandom;
    c.lo         = {lz, ly, lx};
    c.hi         = {hz, hy, hx};
    c.pinned     = 1'b0;
    c.pinned_vis = 1'b0;
    return c;
  endfunction

  function automatic cmd_t pin(input cmd_t c, input bit vis);
    cmd_t r;
    r            = c;
    r.pinned     = 1'b1;
    r.pinned_vis = vis;
    return r;
  endfunction

  // Matrix entry in one of several flavors
  function automatic logic [VAL_W-1:0] mat_value(input int style);
    logic [VAL_W-1:0] v;
    case (style)
      0: v = $urandom;
      1: begin
        if ($urandom_range(0, 3) == 0) v = '0;
        else v = VAL_W'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h0001_0000;
          default: v = '0;
        endcase
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // Box sized to the matrix flavor; some come with min above max
  function automatic cmd_t rand_box(input int style);
    logic [2:0][VAL_W-1:0] lo;
    logic [2:0][VAL_W-1:0] hi;
    logic [VAL_W-1:0]      tmp;
    int                    ctr;
    int                    half;
    for (int a = 0; a < 3; a++) begin
      if (style == 0 || $urandom_range(0, 99) < 15) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
        if ($urandom_range(0, 9) != 0 && $signed(lo[a]) > $signed(hi[a])) begin
          tmp   = lo[a];
          lo[a] = hi[a];
          hi[a] = tmp;
        end
      end else begin
        ctr   = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        half  = $urandom_range(0, 1 << 17);
        lo[a] = VAL_W'(ctr - half);
        hi[a] = VAL_W'(ctr + half);
        if ($urandom_range(0, 9) == 0) begin
          lo[a] = VAL_W'(ctr + half);
          hi[a] = VAL_W'(ctr - half);
        end
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Drive one transaction and hold it until the block takes it
  task automatic send(input cmd_t c);
    start       <= 1'b1;
    op          <= c.op;
    entry_index <= c.idx;
    entry_value <= c.val;
    min_x       <= c.lo[0];
    min_y       <= c.lo[1];
    min_z       <= c.lo[2];
    max_x       <= c.hi[0];
    max_y       <= c.hi[1];
    max_z       <= c.hi[2];
    pin_en      <= c.pinned;
    pin_vis     <= c.pinned_vis;
    @(posedge clk);
    while (busy) @(posedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic load_matrix(input int style);
    for (int i = 0; i < MAT_DEPTH; i++) send(mk_write(4'(i), mat_value(style)));
  endtask

  // Accepted transactions: update the bench matrix or queue the verdict
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      if (op == OP_WRITE) begin
        mat_model[entry_index] = entry_value;
        n_writes++;
      end else begin
        if (pin_en) visible_q.push_back(pin_vis);
        else visible_q.push_back(predict_visible({min_z, min_y, min_x},
                                                 {max_z, max_y, max_x}));
        n_boxes++;
      end
    end
  end

  // Results: compare against the oldest outstanding verdict
  always @(posedge clk) begin
    if (!rst && done) begin
      if (visible_q.size() == 0) begin
        $error("unexpected result: intersects=%0d with nothing outstanding", intersects);
        fails++;
      end else begin
        if (intersects !== visible_q[0]) begin
          $error("intersects mismatch: expected %0d, got %0d", visible_q[0], intersects);
          fails++;
        end
        if (visible_q[0]) n_visible++;
        else n_culled++;
        void'(visible_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("frustum_box_cull_unit test failed");
      $finish;
    end
  end

  initial begin
    int style;
    int sent;
    for (int i = 0; i < MAT_DEPTH; i++) mat_model[i] = '0;

    // Directed table: zero matrix first, then identity, then extreme entries
    plan_q.push_back(pin(mk_box('0, '0, '0, '0, '0, '0), 1'b1));
    plan_q.push_back(pin(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1));
    plan_q.push_back(pin(mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1));
    plan_q.push_back(mk_write(4'd0, 32'h0001_0000));
    plan_q.push_back(mk_write(4'd5, 32'h0001_0000));
    plan_q.push_back(mk_write(4'd10, 32'h0001_0000));
    plan_q.push_back(mk_write(4'd15, 32'h0001_0000));
    // unit cube around the origin, then boxes off to one side, then inverted and extreme boxes
    plan_q.push_back(mk_box(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000,
                            32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    plan_q.push_back(mk_box(32'h0002_0000, '0, '0, 32'h0003_0000, '0, '0));
    plan_q.push_back(mk_box('0, 32'hFFFD_0000, '0, '0, 32'hFFFE_0000, '0));
    plan_q.push_back(mk_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000));
    plan_q.push_back(mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    plan_q.push_back(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    plan_q.push_back(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    plan_q.push_back(mk_write(4'd15, 32'h8000_0000));
    plan_q.push_back(mk_box('0, '0, '0, '0, '0, '0));
    plan_q.push_back(mk_write(4'd12, 32'h7FFF_FFFF));
    plan_q.push_back(mk_write(4'd3, 32'h8000_0000));
    plan_q.push_back(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    plan_q.push_back(mk_box(32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                            32'h8000_0000, 32'h0, 32'h7FFF_FFFF));
    plan_q.push_back(mk_write(4'd15, 32'h7FFF_FFFF));
    plan_q.push_back(mk_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'h0000_0001, 32'h0000_0001, 32'h0000_0001));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 8;
    foreach (plan_q[i]) send(plan_q[i]);

    // Random part: three idling phases, each with matrix reloads and box streams
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 69 : 0;
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        style = $urandom_range(0, 9);
        style = (style < 3) ? 0 : (style < 8) ? 1 : (style < 9) ? 2 : 3;
        load_matrix(style);
        sent += MAT_DEPTH;
        for (int b = 0; b < 80 && sent < RANDOM_ITEMS / 3; b++) begin
          if ($urandom_range(0, 99) < 6)
            send(mk_write(4'($urandom_range(0, 15)), mat_value($urandom_range(0, 2))));
          else
            send(rand_box(style));
          sent++;
        end
      end
    end
    start <= 1'b0;

    while (visible_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (visible_q.size() != 0) begin
      $error("%0d results never arrived", visible_q.size());
      fails++;
    end
    $display("Ran %0d matrix writes and %0d box tests (%0d visible, %0d culled).",
             n_writes, n_boxes, n_visible, n_culled);
    $display("Check failures: %0d over %0d cycles.", fails, cycles);
    if (fails == 0) begin
      $display("frustum_box_cull_unit test passed");
    end else begin
      $display("frustum_box_cull_unit test failed");
    end
    $finish;
  end

endmodule
